// File: hw/rtl/hotp_pkg.sv
// Shared types, constants and helpers for the HMAC-SHA1 one-time code generator.
// No dependencies.
package hotp_pkg;

    localparam int KeyBytes = 32;
    localparam int KeyLenW  = 6;

    localparam logic [7:0]  IPAD    = 8'h36;
    localparam logic [7:0]  OPAD    = 8'h5c;
    localparam logic [19:0] CODE_MOD = 20'd1000000;
    // ceil(2^39 / 15625): exact quotient by 15625 for inputs below 2^25
    localparam logic [25:0] CODE_RECIP = 26'd35184373;

    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_KLEN = 3'd4;

    localparam logic [159:0] SHA_INIT =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_SUB,
        ST_MOD,
        ST_DONE
    } state_t;

    // Compression request: start strobe, message block and input hash
    typedef struct packed {
        logic         start;
        logic [511:0] block;
        logic [159:0] hin;
    } sha_req_t;

    typedef struct packed {
        logic         done;
        logic [159:0] hout;
    } sha_rsp_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

// File: hw/rtl/hmac_sha1_otp_generator.sv
// Top level: HMAC-SHA1 sequencer, dynamic truncation and modulo 1000000.
// Depends on hotp_pkg and hotp_sha1_core.
//
// channel   direction  fields (low bit up)
// s_axis    in         tdata[63:0] step_counter
// m_axis    out        tdata[19:0] otp_code, tdata[50:20] truncated_value
// cfg       in         cfg_index selects key_word_0..3, key_length
//
// An item takes 4 compressions (load, 80 rounds, digest add) and 2 modulo steps;
// a new step_counter is accepted only after the result has been taken.
// One round unit is shared by all compressions; the modulo uses a reciprocal multiply and a subtract.
// Reset clears keys and sets key_length to 20. A result holds until m_axis_tready.
// s_axis_tready is high only while idle.
module hmac_sha1_otp_generator
    import hotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // step_counter
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // otp_code, truncated_value, zero fill
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [255:0]         key_reg;
    logic [KeyLenW-1:0]   klen_reg;
    state_t               state_reg, state_next;
    logic [1:0]           pass_reg, pass_next;
    logic [63:0]          ctr_reg, ctr_next;
    logic [159:0]         h_reg, h_next;
    logic [159:0]         ih_reg, ih_next;
    logic [30:0]          val_reg, val_next;
    logic [50:0]          prod_reg, prod_next;
    logic [19:0]          code_reg, code_next;
    logic [511:0]         k0, kblk, blk;
    logic [KeyLenW-1:0]   len;
    sha_req_t             req;
    sha_rsp_t             rsp;
    logic [159:0]         mac;
    logic [3:0]           off;
    logic [31:0]          word;
    logic [31:0]          qm, diff;

    hotp_sha1_core u_core (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_comb
    begin
        len = (klen_reg > 6'd32) ? 6'd32 : klen_reg;
        k0  = '0;
        for (int i = 0; i < KeyBytes; i++)
        begin
            if (i < len)
                k0[511 - 8 * i -: 8] = key_reg[255 - 8 * i -: 8];
        end
        kblk = k0 ^ {64{pass_reg[1] ? OPAD : IPAD}};
        case (pass_reg)
            2'd0, 2'd2: blk = kblk;
            2'd1:       blk = {ctr_reg, 8'h80, 376'd0, 64'd576};
            default:    blk = {ih_reg, 8'h80, 280'd0, 64'd672};
        endcase
        mac  = rsp.hout;
        off  = mac[3:0];
        word = mac[159 - 8 * off -: 32];
        qm   = {20'd0, prod_reg[50:39]} * {12'd0, CODE_MOD};
        diff = {1'b0, val_reg} - qm;
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        ctr_next   = ctr_reg;
        h_next     = h_reg;
        ih_next    = ih_reg;
        val_next   = val_reg;
        prod_next  = prod_reg;
        code_next  = code_reg;
        req.start  = 1'b0;
        req.block  = blk;
        req.hin    = (pass_reg[0]) ? h_reg : SHA_INIT;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ctr_next   = s_axis_tdata;
                    pass_next  = 2'd0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                req.start  = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rsp.done)
                begin
                    h_next = rsp.hout;
                    if (pass_reg == 2'd1)
                        ih_next = rsp.hout;
                    if (pass_reg == 2'd3)
                    begin
                        val_next   = word[30:0];
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_MOD:
            begin
                prod_next  = {26'd0, val_reg[30:6]} * {25'd0, CODE_RECIP};
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                code_next  = diff[19:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
            key_reg   <= '0;
            klen_reg  <= 6'd20;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY0: key_reg[255:192] <= cfg_data;
                    CFG_KEY1: key_reg[191:128] <= cfg_data;
                    CFG_KEY2: key_reg[127:64]  <= cfg_data;
                    CFG_KEY3: key_reg[63:0]    <= cfg_data;
                    CFG_KLEN: klen_reg         <= cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg  <= ctr_next;
        h_reg    <= h_next;
        ih_reg   <= ih_next;
        val_reg  <= val_next;
        prod_reg <= prod_next;
        code_reg <= code_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);
    assign m_axis_tdata  = {5'd0, val_reg, code_reg};

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> code_reg < CODE_MOD) else $error("code out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");

endmodule

// File: hw/rtl/hotp_sha1_core.sv
// One SHA-1 compression, one round per cycle over a 16-word schedule window.
// Depends on hotp_pkg.
module hotp_sha1_core
    import hotp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sha_req_t req,
    output sha_rsp_t rsp
);

    logic [511:0] w_reg, w_next;
    logic [159:0] h_reg, h_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  f, k, wi, wn;

    always_comb
    begin
        wi = w_reg[511:480];
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        wn = rotl(w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480], 1);

        w_next    = w_reg;
        h_next    = h_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            w_next    = req.block;
            h_next    = req.hin;
            {a_next, b_next, c_next, d_next, e_next} = req.hin;
            rnd_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next   = rotl(a_reg, 5) + f + e_reg + k + wi;
            b_next   = a_reg;
            c_next   = rotl(b_reg, 30);
            d_next   = c_reg;
            e_next   = d_reg;
            w_next   = {w_reg[479:0], wn};
            rnd_next = rnd_reg + 7'd1;
            if (rnd_reg == 7'd79)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        h_reg <= h_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hout = {h_reg[159:128] + a_reg, h_reg[127:96] + b_reg,
                       h_reg[95:64] + c_reg, h_reg[63:32] + d_reg, h_reg[31:0] + e_reg};

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !req.start) |=> !busy_reg) else $error("spurious start");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(rnd_reg) == 7'd79) else $error("early done");

endmodule
